>>> sv/tabular_q_learning_update_defines.svh
// assertion macros for the q-learning update block
// no dependencies; asserting files include this header by name
`ifndef TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH
`define TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TQLU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TQLU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define TQLU_ASSERT(name, prop, msg)
`define TQLU_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

>>> sv/tqlu_pkg.sv
// shared types and constants of the q-learning update block
// no dependencies
package tqlu_pkg;

  localparam int NumStates    = 256;
  localparam int NumActions   = 4;
  localparam int ValueWidth   = 16;
  localparam int StateBits    = $clog2(NumStates);
  localparam int ActionBits   = $clog2(NumActions);
  localparam int RowWidth     = NumActions * ValueWidth;
  localparam int CoefWidth    = 16;
  localparam int CoefFrac     = 16;
  localparam int ExploreWidth = 7;
  localparam int RewardWidth  = 8;
  localparam int FracBits     = 8;
  localparam int DiffWidth    = ValueWidth + 2;
  localparam int ProdWidth    = CoefWidth + 1 + DiffWidth;
  localparam int RndWidth     = ProdWidth - CoefFrac;
  localparam int SumWidth     = RndWidth + 1;
  localparam int RoundHalf    = 2 ** (CoefFrac - 1);

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CfgLearningRate  = 2'd0;
  localparam cfg_index_t CfgDiscount      = 2'd1;
  localparam cfg_index_t CfgExplore       = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_NEXT,
    ST_RD_CUR,
    ST_TARGET,
    ST_MUL_ALPHA,
    ST_WRITE,
    ST_CHOOSE
  } state_e;

  typedef struct packed {
    logic                 rd_en;
    logic [StateBits-1:0] rd_addr;
    logic                 wr_en;
    logic [StateBits-1:0] wr_addr;
  } qmem_req_t;

endpackage

>>> sv/tqlu_qmem.sv
// q table storage, one row of all action values per state
// depends on tqlu_pkg; clears itself row by row after reset
module tqlu_qmem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tqlu_pkg::qmem_req_t           req_i,
  input  logic [tqlu_pkg::RowWidth-1:0] wdata_i,
  output logic [tqlu_pkg::RowWidth-1:0] rdata_o,
  output logic                          clearing_o
);
  import tqlu_pkg::*;

  logic [StateBits:0]   clr_cnt_q, clr_cnt_d;
  logic [RowWidth-1:0]  mem [NumStates];
  logic [RowWidth-1:0]  rdata_q;
  logic                 we;
  logic [StateBits-1:0] waddr;
  logic [RowWidth-1:0]  wdata;

  assign clearing_o = (clr_cnt_q != (StateBits + 1)'(NumStates));
  assign clr_cnt_d  = clearing_o ? clr_cnt_q + (StateBits + 1)'(1) : clr_cnt_q;
  assign rdata_o    = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    we    = clearing_o | req_i.wr_en;
    waddr = clearing_o ? clr_cnt_q[StateBits-1:0] : req_i.wr_addr;
    wdata = clearing_o ? '0 : wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

endmodule

>>> sv/tabular_q_learning_update.sv
// Q-learning update with epsilon-greedy action choice. After reset the table
// is cleared row by row with busy high. An item is taken when start is high
// and busy is low. A select-only item reads the row of the next state, then picks
// the action; an update item reads the row of the next state, then that of the
// current state, then makes two multiplies (gamma*max, alpha*diff) through a single
// shared multiplier, a write-back and the action pick. The memory has one read
// port, so the two row reads are made one after the other. busy is low again in the
// done cycle, so the next item can be taken there. Results are valid in the one
// cycle that done_o is high and stay until the next item is accepted. The user must
// write configuration only while busy is low; the block does not enforce it.
// depends on tqlu_pkg, tqlu_qmem and tabular_q_learning_update_defines.svh
`include "tabular_q_learning_update_defines.svh"

module tabular_q_learning_update (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  tqlu_pkg::cfg_index_t                 cfg_index_i,
  input  logic [tqlu_pkg::CoefWidth-1:0]       cfg_wdata_i,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type_i,
  input  logic [tqlu_pkg::StateBits-1:0]       state_index_i,
  input  logic [tqlu_pkg::ActionBits-1:0]      taken_action_i,
  input  logic signed [tqlu_pkg::RewardWidth-1:0] reward_i,
  input  logic [tqlu_pkg::StateBits-1:0]       next_state_i,
  input  logic [tqlu_pkg::ExploreWidth-1:0]    random_percent_i,
  input  logic [tqlu_pkg::ActionBits-1:0]      random_action_i,
  input  logic [tqlu_pkg::ActionBits-1:0]      tie_start_i,
  output logic                                 done_o,
  output logic [tqlu_pkg::ActionBits-1:0]      chosen_action_o,
  output logic signed [tqlu_pkg::ValueWidth-1:0] updated_value_o,
  output logic signed [tqlu_pkg::ValueWidth-1:0] best_next_value_o,
  output logic                                 saturated_o
);
  import tqlu_pkg::*;

  localparam logic signed [SumWidth-1:0] SumMax = SumWidth'((2 ** (ValueWidth - 1)) - 1);
  localparam logic signed [SumWidth-1:0] SumMin = ~SumMax;

  state_e state_q, state_d;
  logic   accept;
  logic   clearing;
  logic   done_q;

  logic [CoefWidth-1:0]    alpha_q, gamma_q;
  logic [ExploreWidth-1:0] explore_q;

  logic                        req_q;
  logic [StateBits-1:0]        cur_q, nxt_q;
  logic [ActionBits-1:0]       act_q, rand_act_q, tie_q, chosen_q;
  logic signed [RewardWidth-1:0] reward_q;
  logic [ExploreWidth-1:0]     rand_pct_q;

  logic [RowWidth-1:0]           row_q, srow_q, wrow, rdata;
  logic signed [ValueWidth-1:0]  best_q, rd_max, new_val, new_q, cur_val;
  logic signed [DiffWidth-1:0]   diff_q, mul_b;
  logic [CoefWidth-1:0]          mul_coef;
  logic signed [ProdWidth-1:0]   mul_p, prod_q, prod_rnd;
  logic signed [RndWidth-1:0]    rnd, diff_full;
  logic signed [SumWidth-1:0]    sum;
  logic                          sat, sat_q;
  logic [ActionBits-1:0]         g_best, chosen;
  logic signed [ValueWidth-1:0]  g_max;
  qmem_req_t                     mreq;

  tqlu_qmem u_qmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mreq),
    .wdata_i    (wrow),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  assign busy   = clearing | (state_q != ST_IDLE);
  assign accept = start & ~busy;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= CoefWidth'(6554);
      gamma_q   <= CoefWidth'(58982);
      explore_q <= ExploreWidth'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgLearningRate: alpha_q   <= cfg_wdata_i;
        CfgDiscount:     gamma_q   <= cfg_wdata_i;
        CfgExplore:      explore_q <= cfg_wdata_i[ExploreWidth-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier and rounding
  always_comb begin
    if (state_q == ST_RD_CUR) begin
      mul_coef = gamma_q;
      mul_b    = DiffWidth'(best_q);
    end else begin
      mul_coef = alpha_q;
      mul_b    = diff_q;
    end
    mul_p    = ProdWidth'($signed({1'b0, mul_coef})) * ProdWidth'(mul_b);
    prod_rnd = prod_q + ProdWidth'(RoundHalf);
    rnd      = $signed(prod_rnd[ProdWidth-1:CoefFrac]);
  end

  // target, difference and saturated sum
  always_comb begin
    cur_val   = $signed(srow_q[act_q*ValueWidth +: ValueWidth]);
    diff_full = RndWidth'($signed({reward_q, {FracBits{1'b0}}})) + rnd - RndWidth'(cur_val);
    sum       = SumWidth'(cur_val) + SumWidth'(rnd);
    sat       = 1'b0;
    if (sum > SumMax) begin
      new_val = SumMax[ValueWidth-1:0];
      sat     = 1'b1;
    end else if (sum < SumMin) begin
      new_val = SumMin[ValueWidth-1:0];
      sat     = 1'b1;
    end else begin
      new_val = sum[ValueWidth-1:0];
    end
    wrow = srow_q;
    wrow[act_q*ValueWidth +: ValueWidth] = new_val;
  end

  // row max of the freshly read row
  always_comb begin
    rd_max = $signed(rdata[ValueWidth-1:0]);
    for (int i = 1; i < NumActions; i++) begin
      if ($signed(rdata[i*ValueWidth +: ValueWidth]) > rd_max) begin
        rd_max = $signed(rdata[i*ValueWidth +: ValueWidth]);
      end
    end
  end

  // greedy pick with tie start, then exploration
  always_comb begin
    g_best = tie_q;
    g_max  = $signed(row_q[tie_q*ValueWidth +: ValueWidth]);
    for (int i = 0; i < NumActions; i++) begin
      if ($signed(row_q[i*ValueWidth +: ValueWidth]) > g_max) begin
        g_max  = $signed(row_q[i*ValueWidth +: ValueWidth]);
        g_best = ActionBits'(i);
      end
    end
    chosen = (rand_pct_q < explore_q) ? rand_act_q : g_best;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    mreq.rd_en   = 1'b0;
    mreq.rd_addr = next_state_i;
    mreq.wr_en   = 1'b0;
    mreq.wr_addr = cur_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mreq.rd_en = 1'b1;
          state_d    = ST_RD_NEXT;
        end
      end
      ST_RD_NEXT: begin
        if (req_q) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = cur_q;
          state_d      = ST_RD_CUR;
        end else begin
          state_d = ST_CHOOSE;
        end
      end
      ST_RD_CUR:    state_d = ST_TARGET;
      ST_TARGET:    state_d = ST_MUL_ALPHA;
      ST_MUL_ALPHA: state_d = ST_WRITE;
      ST_WRITE: begin
        mreq.wr_en = 1'b1;
        state_d    = ST_CHOOSE;
      end
      ST_CHOOSE:    state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_CHOOSE);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_type_i;
      cur_q      <= state_index_i;
      act_q      <= taken_action_i;
      reward_q   <= reward_i;
      nxt_q      <= next_state_i;
      rand_pct_q <= random_percent_i;
      rand_act_q <= random_action_i;
      tie_q      <= tie_start_i;
      new_q      <= '0;
      sat_q      <= 1'b0;
    end
    unique case (state_q)
      ST_RD_NEXT: begin
        row_q  <= rdata;
        best_q <= rd_max;
      end
      ST_RD_CUR: begin
        srow_q <= rdata;
        prod_q <= mul_p;
      end
      ST_TARGET:    diff_q <= diff_full[DiffWidth-1:0];
      ST_MUL_ALPHA: prod_q <= mul_p;
      ST_WRITE: begin
        new_q <= new_val;
        sat_q <= sat;
        // same state: the pick sees the new entry
        if (cur_q == nxt_q) begin
          row_q[act_q*ValueWidth +: ValueWidth] <= new_val;
        end
      end
      ST_CHOOSE:    chosen_q <= chosen;
      default: ;
    endcase
  end

  assign done_o            = done_q;
  assign chosen_action_o   = chosen_q;
  assign updated_value_o   = new_q;
  assign best_next_value_o = best_q;
  assign saturated_o       = sat_q;

  `TQLU_ASSERT_NEXT(a_done_single, done_q, !done_q, "done strobe longer than one cycle")
  `TQLU_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted beat did not raise busy")
  `TQLU_ASSERT(a_write_only_update, mreq.wr_en |-> req_q, "table write on select-only beat")
  `TQLU_ASSERT(a_select_zero, (done_q && !req_q) |-> (new_q == '0 && !sat_q),
               "select-only result not zero")
  `TQLU_ASSERT(a_sat_limit, (done_q && sat_q) |->
               (new_q == SumMax[ValueWidth-1:0] || new_q == SumMin[ValueWidth-1:0]),
               "saturated value not at a limit")

endmodule
